/* src/sfti_pkg.sv */
// sorted flaw table package: codes, controller states and control structs
// no dependencies
package sfti_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 256;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_ADDED  = 2'd0;
   localparam logic [1:0] ST_MERGED = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   localparam logic [1:0] CSR_CYLINDERS = 2'd0;
   localparam logic [1:0] CSR_TRACKS    = 2'd1;
   localparam logic [1:0] CSR_BYTES     = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_SCAN, S_SCAN_CMP, S_SHIFT, S_SHIFT_WR, S_READ_WAIT, S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic       load_req;
      logic       idx_to_count;
      logic       idx_dec;
      logic       save_pos;
      logic       rd_prev;
      logic       rd_index;
      logic       wr_shift;
      logic       wr_new;
      logic       wr_merge;
      logic       clear;
      logic       set_status;
      logic [1:0] status_code;
      logic       show_data;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       reject_add;
      logic       read_ok;
      logic       idx_zero;
      logic       idx_at_pos;
      logic       key_eq;
      logic       key_gt;
      logic       rsp_busy;
   } dp_status_type;

endpackage

/* src/sfti_ctrl.sv */
// sorted flaw table controller: sequences scan, shift, insert, merge, read, clear and reject
// depends on sfti_pkg
module sfti_ctrl import sfti_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.op == OP_ADD && !stat.reject_add) state_in = S_SCAN;
            else if (stat.op == OP_READ && stat.read_ok) state_in = S_READ_WAIT;
            else state_in = S_RESP;
         end
         S_SCAN: begin
            if (stat.idx_zero) state_in = S_SHIFT;
            else state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (stat.key_eq) state_in = S_RESP;
            else if (stat.key_gt) state_in = S_SCAN;
            else state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (stat.idx_at_pos) state_in = S_RESP;
            else state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR:  state_in = S_SHIFT;
         S_READ_WAIT: state_in = S_RESP;
         S_RESP: begin
            if (!stat.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_req = req_valid;
         end
         S_CHECK: begin
            cmd.set_status = 1'b1;
            cmd.status_code = ST_REJECT;
            if (stat.op == OP_ADD) begin
               cmd.idx_to_count = 1'b1;
            end else if (stat.op == OP_READ) begin
               cmd.status_code = ST_DONE;
               cmd.rd_index = stat.read_ok;
            end else if (stat.op == OP_CLEAR) begin
               cmd.status_code = ST_DONE;
               cmd.clear = 1'b1;
            end
         end
         S_SCAN: begin
            if (stat.idx_zero) begin
               cmd.save_pos = 1'b1;
               cmd.idx_to_count = 1'b1;
            end else begin
               cmd.rd_prev = 1'b1;
            end
         end
         S_SCAN_CMP: begin
            if (stat.key_eq) begin
               cmd.wr_merge = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status_code = ST_MERGED;
            end else if (stat.key_gt) begin
               cmd.idx_dec = 1'b1;
            end else begin
               cmd.save_pos = 1'b1;
               cmd.idx_to_count = 1'b1;
            end
         end
         S_SHIFT: begin
            if (stat.idx_at_pos) begin
               cmd.wr_new = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status_code = ST_ADDED;
            end else begin
               cmd.rd_prev = 1'b1;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_dec = 1'b1;
         end
         S_READ_WAIT: begin
            cmd.set_status = 1'b1;
            cmd.status_code = ST_DONE;
            cmd.show_data = 1'b1;
         end
         S_RESP: begin
            cmd.rsp_load = !stat.rsp_busy;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* src/sfti_dp.sv */
// sorted flaw table datapath: entry memory, counters, geometry registers, result register
// depends on sfti_pkg
module sfti_dp import sfti_pkg::*; #(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type stat,
   input  logic [1:0]    req_op,
   input  logic [14:0]   req_flaw_cylinder,
   input  logic [7:0]    req_flaw_track,
   input  logic [15:0]   req_flaw_offset,
   input  logic [15:0]   req_flaw_length,
   input  logic [1:0]    req_flaw_source,
   input  logic [7:0]    req_read_index,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [1:0]    rsp_status,
   output logic [8:0]    rsp_entry_count,
   output logic          rsp_read_valid,
   output logic [14:0]   rsp_out_cylinder,
   output logic [7:0]    rsp_out_track,
   output logic [15:0]   rsp_out_offset,
   output logic [15:0]   rsp_out_length,
   output logic [1:0]    rsp_out_source,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = (CW > 9) ? CW : 9;
   localparam int EW = 57;
   localparam int KW = 39;

   logic [EW-1:0] mem [MAX_ENTRIES];
   logic [EW-1:0] rd_data_ff;
   logic [EW-1:0] new_ff;
   logic [1:0]    op_ff;
   logic [7:0]    index_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff;
   logic [1:0]    status_ff;
   logic          show_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   cyl_cnt_ff;
   logic [8:0]    trk_cnt_ff;
   logic [15:0]   bytes_ff;
   logic [1:0]    rsp_status_ff;
   logic [8:0]    rsp_entry_count_ff;
   logic          rsp_read_valid_ff;
   logic [14:0]   rsp_out_cylinder_ff;
   logic [7:0]    rsp_out_track_ff;
   logic [15:0]   rsp_out_offset_ff;
   logic [15:0]   rsp_out_length_ff;
   logic [1:0]    rsp_out_source_ff;

   logic [CW-1:0] idx_m1;
   logic [IW-1:0] index_x, count_x, max_x;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, merged;
   logic [1:0]    min_src;

   assign idx_m1  = idx_ff - CW'(1);
   assign index_x = IW'(index_ff);
   assign count_x = IW'(count_ff);
   assign max_x   = IW'(MAX_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         cyl_cnt_ff <= 16'd32768;
         trk_cnt_ff <= 9'd256;
         bytes_ff   <= 16'd65535;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CYLINDERS: cyl_cnt_ff <= csr_wdata;
            CSR_TRACKS:    trk_cnt_ff <= csr_wdata[8:0];
            CSR_BYTES:     bytes_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_op;
         index_ff <= req_read_index;
         new_ff   <= {req_flaw_cylinder, req_flaw_track, req_flaw_offset,
                      req_flaw_length, req_flaw_source};
      end
      if (cmd.save_pos) pos_ff <= idx_ff;
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
         show_ff   <= cmd.show_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) count_in = '0;
      else if (cmd.wr_new) count_in = count_ff + CW'(1);
      idx_in = idx_ff;
      if (cmd.idx_to_count) idx_in = count_ff;
      else if (cmd.idx_dec) idx_in = idx_m1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   assign min_src = (rd_data_ff[1:0] > new_ff[1:0]) ? new_ff[1:0] : rd_data_ff[1:0];
   assign merged  = {rd_data_ff[EW-1:2], min_src};

   always_comb begin
      wr_en   = cmd.wr_shift | cmd.wr_new | cmd.wr_merge;
      wr_addr = cmd.wr_merge ? idx_m1[AW-1:0] : idx_ff[AW-1:0];
      wr_data = new_ff;
      if (cmd.wr_shift) wr_data = rd_data_ff;
      else if (cmd.wr_merge) wr_data = merged;
      rd_addr = cmd.rd_index ? index_x[AW-1:0] : idx_m1[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_prev | cmd.rd_index) rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      stat.op         = op_ff;
      stat.reject_add = (count_x >= max_x)
                        || ({1'b0, new_ff[56:42]} >= cyl_cnt_ff)
                        || ({1'b0, new_ff[41:34]} >= trk_cnt_ff)
                        || (new_ff[33:18] >= bytes_ff);
      stat.read_ok    = (index_x < count_x) && (index_x < max_x);
      stat.idx_zero   = (idx_ff == '0);
      stat.idx_at_pos = (idx_ff == pos_ff);
      stat.key_eq     = (rd_data_ff[EW-1:EW-KW] == new_ff[EW-1:EW-KW]);
      stat.key_gt     = (rd_data_ff[EW-1:EW-KW] > new_ff[EW-1:EW-KW]);
      stat.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff       <= status_ff;
         rsp_entry_count_ff  <= count_x[8:0];
         rsp_read_valid_ff   <= show_ff;
         rsp_out_cylinder_ff <= show_ff ? rd_data_ff[56:42] : 15'd0;
         rsp_out_track_ff    <= show_ff ? rd_data_ff[41:34] : 8'd0;
         rsp_out_offset_ff   <= show_ff ? rd_data_ff[33:18] : 16'd0;
         rsp_out_length_ff   <= show_ff ? rd_data_ff[17:2]  : 16'd0;
         rsp_out_source_ff   <= show_ff ? rd_data_ff[1:0]   : 2'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;
   assign rsp_read_valid   = rsp_read_valid_ff;
   assign rsp_out_cylinder = rsp_out_cylinder_ff;
   assign rsp_out_track    = rsp_out_track_ff;
   assign rsp_out_offset   = rsp_out_offset_ff;
   assign rsp_out_length   = rsp_out_length_ff;
   assign rsp_out_source   = rsp_out_source_ff;

endmodule

/* src/sorted_flaw_table_insert.sv */
// Sorted flaw table, top level: controller and datapath.
// An add searches down from the top of the table past each stored entry above the
// insertion point, then moves each such entry up one place and writes the new one; a
// duplicate merges into the matching entry after searching past the entries above it.
// A read, a clear and a reject need no search or move, and any result may wait on
// rsp_stall for the previous one. All entry moves go through the table memory one entry
// at a time. The table is empty after reset without any clearing pass; req_stall is high
// from acceptance until the result is registered, and a finished result may wait on
// rsp_stall while a new item is taken.
// depends on sfti_pkg, sfti_ctrl, sfti_dp
module sorted_flaw_table_insert import sfti_pkg::*; #(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [14:0] req_flaw_cylinder,
   input  logic [7:0]  req_flaw_track,
   input  logic [15:0] req_flaw_offset,
   input  logic [15:0] req_flaw_length,
   input  logic [1:0]  req_flaw_source,
   input  logic [7:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_entry_count,
   output logic        rsp_read_valid,
   output logic [14:0] rsp_out_cylinder,
   output logic [7:0]  rsp_out_track,
   output logic [15:0] rsp_out_offset,
   output logic [15:0] rsp_out_length,
   output logic [1:0]  rsp_out_source,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   sfti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfti_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_flaw_cylinder (req_flaw_cylinder),
      .req_flaw_track    (req_flaw_track),
      .req_flaw_offset   (req_flaw_offset),
      .req_flaw_length   (req_flaw_length),
      .req_flaw_source   (req_flaw_source),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_out_cylinder  (rsp_out_cylinder),
      .rsp_out_track     (rsp_out_track),
      .rsp_out_offset    (rsp_out_offset),
      .rsp_out_length    (rsp_out_length),
      .rsp_out_source    (rsp_out_source),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

endmodule

/* tb/sv/tb_top.sv */
// testbench for the sorted flaw table: directed and random items checked against
// an in-bench table predictor, with random gaps on the request side and stalls on results
// depends on sfti_pkg and sorted_flaw_table_insert
module tb_top import sfti_pkg::*; ();

   localparam int TABLE_DEPTH = DEFAULT_MAX_ENTRIES;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 20000000;

   typedef struct packed {
      logic [14:0] cyl;
      logic [7:0]  trk;
      logic [15:0] off;
      logic [15:0] len;
      logic [1:0]  src;
   } flaw_entry_type;

   typedef struct packed {
      logic [1:0]     status;
      logic [8:0]     count;
      logic           read_valid;
      flaw_entry_type shown;
   } flaw_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_CLEAR;
   logic [14:0] req_flaw_cylinder = '0;
   logic [7:0]  req_flaw_track = '0;
   logic [15:0] req_flaw_offset = '0;
   logic [15:0] req_flaw_length = '0;
   logic [1:0]  req_flaw_source = '0;
   logic [7:0]  req_read_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [8:0]  rsp_entry_count;
   logic        rsp_read_valid;
   logic [14:0] rsp_out_cylinder;
   logic [7:0]  rsp_out_track;
   logic [15:0] rsp_out_offset;
   logic [15:0] rsp_out_length;
   logic [1:0]  rsp_out_source;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_CYLINDERS;
   logic [15:0] csr_wdata = '0;

   flaw_entry_type  flaw_table [TABLE_DEPTH];
   int unsigned     table_count;
   int unsigned     geo_cylinders, geo_tracks, geo_bytes;
   flaw_result_type pending_results[$];
   int unsigned     fail_count;
   int unsigned     cycle_count;
   bit              calm;

   sorted_flaw_table_insert dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 25);

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
      fail_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      flaw_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", int'(rsp_status), 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", int'(rsp_status), int'(want.status));
            if (rsp_entry_count !== want.count)
               report_mismatch("entry_count", int'(rsp_entry_count), int'(want.count));
            if (rsp_read_valid !== want.read_valid)
               report_mismatch("read_valid", int'(rsp_read_valid), int'(want.read_valid));
            if (rsp_out_cylinder !== want.shown.cyl)
               report_mismatch("cylinder", int'(rsp_out_cylinder), int'(want.shown.cyl));
            if (rsp_out_track !== want.shown.trk)
               report_mismatch("track", int'(rsp_out_track), int'(want.shown.trk));
            if (rsp_out_offset !== want.shown.off)
               report_mismatch("offset", int'(rsp_out_offset), int'(want.shown.off));
            if (rsp_out_length !== want.shown.len)
               report_mismatch("length", int'(rsp_out_length), int'(want.shown.len));
            if (rsp_out_source !== want.shown.src)
               report_mismatch("source", int'(rsp_out_source), int'(want.shown.src));
         end
      end
   end

   // table predictor: insert in key order, merge duplicates to the lower source
   function automatic flaw_result_type table_update(input logic [1:0] op,
                                                    input flaw_entry_type add,
                                                    input logic [7:0] index);
      flaw_result_type r;
      int unsigned pos;
      r = '0;
      r.status = ST_REJECT;
      case (op)
         OP_ADD: begin
            if (table_count < TABLE_DEPTH && 32'(add.cyl) < geo_cylinders &&
                32'(add.trk) < geo_tracks && 32'(add.off) < geo_bytes) begin
               pos = 0;
               r.status = ST_ADDED;
               while (pos < table_count) begin
                  if ({flaw_table[pos].cyl, flaw_table[pos].trk, flaw_table[pos].off} ==
                      {add.cyl, add.trk, add.off}) begin
                     if (flaw_table[pos].src > add.src) flaw_table[pos].src = add.src;
                     r.status = ST_MERGED;
                     break;
                  end
                  if ({flaw_table[pos].cyl, flaw_table[pos].trk, flaw_table[pos].off} >
                      {add.cyl, add.trk, add.off}) break;
                  pos++;
               end
               if (r.status == ST_ADDED) begin
                  for (int i = table_count; i > pos; i--) flaw_table[i] = flaw_table[i - 1];
                  flaw_table[pos] = add;
                  table_count++;
               end
            end
         end
         OP_READ: begin
            r.status = ST_DONE;
            if (32'(index) < table_count) begin
               r.read_valid = 1'b1;
               r.shown = flaw_table[index];
            end
         end
         OP_CLEAR: begin
            table_count = 0;
            r.status = ST_DONE;
         end
         default: ;
      endcase
      r.count = table_count[8:0];
      return r;
   endfunction

   task automatic send_item(input logic [1:0] op, input flaw_entry_type add,
                            input logic [7:0] index);
      if (!calm && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_flaw_cylinder <= add.cyl;
      req_flaw_track <= add.trk;
      req_flaw_offset <= add.off;
      req_flaw_length <= add.len;
      req_flaw_source <= add.src;
      req_read_index <= index;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(table_update(op, add, index));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         CSR_CYLINDERS: geo_cylinders = 32'(value);
         CSR_TRACKS:    geo_tracks = 32'(value[8:0]);
         CSR_BYTES:     geo_bytes = 32'(value);
         default: ;
      endcase
   endtask

   function automatic flaw_entry_type make_entry(input int cyl, input int trk, input int off,
                                                 input int len, input int src);
      flaw_entry_type e;
      e.cyl = 15'(cyl);
      e.trk = 8'(trk);
      e.off = 16'(off);
      e.len = 16'(len);
      e.src = 2'(src);
      return e;
   endfunction

   task automatic test_directed();
      flaw_entry_type none;
      none = '0;
      send_item(OP_READ, none, 8'd0);
      send_item(OP_ADD, make_entry(32767, 255, 65534, 16'hFFFF, 3), 8'd0);
      send_item(OP_ADD, make_entry(0, 0, 0, 0, 2), 8'd0);
      send_item(OP_ADD, make_entry(0, 0, 65535, 1, 0), 8'd0);
      send_item(OP_ADD, make_entry(100, 7, 500, 16'h5A5A, 1), 8'd0);
      send_item(OP_ADD, make_entry(100, 6, 500, 16'hA5A5, 2), 8'd0);
      send_item(OP_ADD, make_entry(100, 7, 500, 3, 2), 8'd0);
      send_item(OP_ADD, make_entry(100, 7, 500, 4, 0), 8'd0);
      send_item(OP_ADD, make_entry(32767, 255, 65534, 9, 3), 8'd0);
      send_item(OP_ADD, make_entry(0, 0, 0, 7, 1), 8'd0);
      send_item(OP_ADD, make_entry(21845, 170, 43690, 16'h5555, 1), 8'd0);
      for (int i = 0; i < 6; i++) send_item(OP_READ, none, i[7:0]);
      send_item(OP_READ, none, 8'd255);
      send_item(OP_UNUSED, make_entry(1, 1, 1, 1, 1), 8'd1);
      send_item(OP_READ, none, 8'd1);
      send_item(OP_CLEAR, none, 8'd0);
      send_item(OP_READ, none, 8'd0);
   endtask

   task automatic test_geometry();
      flaw_entry_type none;
      none = '0;
      write_csr(CSR_CYLINDERS, 16'd4);
      write_csr(CSR_TRACKS, 16'd2);
      write_csr(CSR_BYTES, 16'd8);
      write_csr(CSR_UNUSED, 16'hFFFF);
      send_item(OP_ADD, make_entry(3, 1, 7, 1, 1), 8'd0);
      send_item(OP_ADD, make_entry(4, 1, 7, 1, 1), 8'd0);
      send_item(OP_ADD, make_entry(3, 2, 7, 1, 1), 8'd0);
      send_item(OP_ADD, make_entry(3, 1, 8, 1, 1), 8'd0);
      send_item(OP_ADD, make_entry(0, 0, 0, 2, 0), 8'd0);
      write_csr(CSR_CYLINDERS, 16'd0);
      send_item(OP_ADD, make_entry(0, 0, 1, 1, 1), 8'd0);
      write_csr(CSR_CYLINDERS, 16'hFFFF);
      write_csr(CSR_TRACKS, 16'd0);
      send_item(OP_ADD, make_entry(0, 0, 1, 1, 1), 8'd0);
      write_csr(CSR_TRACKS, 16'hFFFF);
      write_csr(CSR_BYTES, 16'd0);
      send_item(OP_ADD, make_entry(0, 0, 1, 1, 1), 8'd0);
      write_csr(CSR_BYTES, 16'd1);
      send_item(OP_ADD, make_entry(32767, 255, 0, 1, 1), 8'd0);
      send_item(OP_ADD, make_entry(5, 3, 1, 1, 1), 8'd0);
      send_item(OP_READ, none, 8'd0);
      send_item(OP_READ, none, 8'd1);
      send_item(OP_CLEAR, none, 8'd0);
      write_csr(CSR_CYLINDERS, 16'd32768);
      write_csr(CSR_TRACKS, 16'd256);
      write_csr(CSR_BYTES, 16'd65535);
   endtask

   task automatic test_full_table();
      flaw_entry_type none;
      none = '0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_item(OP_ADD, make_entry(i * 16, i % 256, i * 3, $urandom, $urandom_range(3)),
                   8'd0);
      send_item(OP_ADD, make_entry(0, 0, 0, 1, 0), 8'd0);
      send_item(OP_ADD, make_entry(20000, 1, 1, 1, 0), 8'd0);
      send_item(OP_READ, none, 8'd255);
      send_item(OP_READ, none, 8'd128);
      send_item(OP_CLEAR, none, 8'd0);
      send_item(OP_ADD, make_entry(20000, 1, 1, 1, 0), 8'd0);
      send_item(OP_CLEAR, none, 8'd0);
   endtask

   task automatic test_random();
      flaw_entry_type e;
      int unsigned    pick;
      logic [7:0]     index;
      logic [1:0]     op;
      for (int n = 0; n < 1550; n++) begin
         calm = (n >= 600 && n < 900);
         if (n % 300 == 299) begin
            case ($urandom_range(3))
               0: write_csr(CSR_CYLINDERS, 16'($urandom_range(1, 16)));
               1: write_csr(CSR_TRACKS, 16'($urandom_range(1, 4)));
               2: write_csr(CSR_BYTES, 16'($urandom_range(1, 32)));
               default: begin
                  write_csr(CSR_CYLINDERS, 16'd32768);
                  write_csr(CSR_TRACKS, 16'd256);
                  write_csr(CSR_BYTES, 16'd65535);
               end
            endcase
         end
         if (n % 250 == 125) wait_idle();
         e = make_entry($urandom, $urandom, $urandom, $urandom, $urandom);
         index = 8'($urandom);
         pick = $urandom_range(99);
         if (pick < 60) begin
            op = OP_ADD;
            if ($urandom_range(3) != 0) begin
               e.cyl = 15'($urandom_range(7));
               e.trk = 8'($urandom_range(3));
               e.off = 16'($urandom_range(15));
            end
         end else if (pick < 92) begin
            op = OP_READ;
            if ($urandom_range(3) != 0) index = 8'($urandom_range(table_count + 1));
         end else if (pick < 97 || table_count > 64) begin
            op = OP_CLEAR;
         end else begin
            op = OP_UNUSED;
         end
         send_item(op, e, index);
      end
      calm = 1'b0;
   endtask

   initial begin
      geo_cylinders = 32768;
      geo_tracks = 256;
      geo_bytes = 65535;
      table_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_geometry();
      test_full_table();
      test_random();
      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
